// ----- rtl/core/ac019_pkg.sv -----
// shared types, item codes and helpers for the category 19 record parser
`default_nettype none

package ac019_pkg;

	localparam int ITEM_LIMIT = 10;

	localparam logic [3:0] KIND_SOURCE      = 4'd0;
	localparam logic [3:0] KIND_MSG_TYPE    = 4'd1;
	localparam logic [3:0] KIND_TIME        = 4'd2;
	localparam logic [3:0] KIND_SYS_STATUS  = 4'd3;
	localparam logic [3:0] KIND_TP_STATUS   = 4'd4;
	localparam logic [3:0] KIND_SENSOR      = 4'd5;
	localparam logic [3:0] KIND_TRANSPONDER = 4'd6;
	localparam logic [3:0] KIND_POSITION    = 4'd7;
	localparam logic [3:0] KIND_HEIGHT      = 4'd8;
	localparam logic [3:0] KIND_UNDULATION  = 4'd9;
	localparam logic [3:0] KIND_END         = 4'd10;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       record_start;
	} in_t;

	typedef struct packed {
		logic [3:0]         item_kind;
		logic signed [31:0] value_a;
		logic signed [31:0] value_b;
		logic [1:0]         code_one;
		logic [1:0]         code_two;
		logic [1:0]         code_three;
		logic [1:0]         code_four;
		logic [4:0]         sensor_flags;
		logic               last_of_record;
	} out_t;

	// byte length of the fixed-size items
	function automatic logic [3:0] fixed_len(input logic [3:0] kind);
		logic [3:0] len;
		unique case (kind)
			KIND_SOURCE:     len = 4'd2;
			KIND_MSG_TYPE:   len = 4'd1;
			KIND_TIME:       len = 4'd3;
			KIND_SYS_STATUS: len = 4'd1;
			KIND_TP_STATUS:  len = 4'd1;
			KIND_POSITION:   len = 4'd8;
			KIND_HEIGHT:     len = 4'd2;
			default:         len = 4'd1;
		endcase
		return len;
	endfunction

	// lowest present item at or above from, ITEM_LIMIT when none
	function automatic logic [3:0] next_item(input logic [ITEM_LIMIT-1:0] pres,
			input logic [3:0] from);
		logic [3:0] res;
		res = 4'(ITEM_LIMIT);
		for (int i = ITEM_LIMIT - 1; i >= 0; i--) begin
			if (pres[i] && (4'(i) >= from)) begin
				res = 4'(i);
			end
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/asterix_cat019_record_parser.sv -----
// top level of the category 19 record parser: input register, decode, result register
// a byte's result (if any) passes the input register, then is written to the result register
// throughput: one byte per cycle while results are taken; the input register and the result register
//   let a new byte in while a finished result still waits to be taken
// reset: arst_n clears the handshake flags and the parser state to idle
`default_nettype none

module asterix_cat019_record_parser (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              byte_valid,
	output logic                   byte_ready,
	input  wire ac019_pkg::in_t    byte_data,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output ac019_pkg::out_t        result_data
);

	// parser phase codes
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_FSPEC = 2'd1;
	localparam logic [1:0] PH_ITEMS = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	localparam int NI = ac019_pkg::ITEM_LIMIT;

	// input register
	logic            valid_s1;
	ac019_pkg::in_t  data_s1;

	// parser state
	logic [1:0]    phase_q;
	logic [NI-1:0] pres_q;
	logic [3:0]    cursor_q;
	logic [3:0]    bcnt_q;
	logic [63:0]   gather_q;
	logic [7:0]    reps_q;
	logic [2:0]    oct_q;

	// result register
	logic            res_valid_q;
	ac019_pkg::out_t res_q;

	// the byte in the input register moves on when the result slot is free
	logic adv;
	assign adv        = valid_s1 && (!res_valid_q || result_ready);
	assign byte_ready = !valid_s1 || adv;

	assign result_valid = res_valid_q;
	assign result_data  = res_q;

	// state as seen by this byte: record_start wipes the old record first
	logic          start;
	logic [7:0]    b;
	logic [1:0]    cur_phase;
	logic [NI-1:0] cur_pres;
	logic [3:0]    cur_cursor;
	logic [3:0]    cur_bcnt;
	logic [63:0]   cur_gather;
	logic [7:0]    cur_reps;
	logic [2:0]    cur_oct;

	assign start      = data_s1.record_start;
	assign b          = data_s1.data_byte;
	assign cur_phase  = start ? PH_FSPEC : phase_q;
	assign cur_pres   = start ? '0 : pres_q;
	assign cur_cursor = start ? '0 : cursor_q;
	assign cur_bcnt   = start ? '0 : bcnt_q;
	assign cur_gather = start ? '0 : gather_q;
	assign cur_reps   = start ? '0 : reps_q;
	assign cur_oct    = start ? '0 : oct_q;

	// next state and result
	logic [1:0]      nx_phase;
	logic [NI-1:0]   nx_pres;
	logic [3:0]      nx_cursor;
	logic [3:0]      nx_bcnt;
	logic [63:0]     nx_gather;
	logic [7:0]      nx_reps;
	logic [2:0]      nx_oct;
	logic            emit;
	logic            done;
	ac019_pkg::out_t r;

	// scratch for the item decode
	logic [63:0] g_new;
	logic [3:0]  bcnt_inc;
	logic [NI-1:0] pres_or;
	logic [3:0]  first_item;
	logic [3:0]  after_item;
	logic [30:0] time_prod;

	assign g_new    = {cur_gather[55:0], b};
	assign bcnt_inc = cur_bcnt + 4'd1;
	// time of day: raw units of 1/128 s to ms is raw*125/16
	assign time_prod = 31'(g_new[23:0]) * 31'd125;

	// fspec bits: first octet gives items 0..6, second octet items 7..9
	always_comb begin
		pres_or = cur_pres;
		if (cur_bcnt == 4'd0) begin
			for (int i = 0; i < 7; i++) begin
				pres_or[i] = cur_pres[i] | b[7-i];
			end
		end else if (cur_bcnt == 4'd1) begin
			for (int i = 7; i < NI; i++) begin
				pres_or[i] = cur_pres[i] | b[14-i];
			end
		end
	end

	assign first_item = ac019_pkg::next_item(pres_or, 4'd0);
	assign after_item = ac019_pkg::next_item(cur_pres, cur_cursor + 4'd1);

	always_comb begin
		nx_phase  = cur_phase;
		nx_pres   = cur_pres;
		nx_cursor = cur_cursor;
		nx_bcnt   = cur_bcnt;
		nx_gather = cur_gather;
		nx_reps   = cur_reps;
		nx_oct    = cur_oct;
		emit      = 1'b0;
		done      = 1'b0;
		r         = '0;

		unique case (cur_phase)
			PH_FSPEC: begin
				nx_pres = pres_or;
				if (cur_bcnt != 4'hf) begin
					nx_bcnt = bcnt_inc;
				end
				// fx clear ends the fspec
				if (!b[0]) begin
					nx_bcnt   = '0;
					nx_gather = '0;
					nx_cursor = first_item;
					if (first_item < 4'(NI)) begin
						nx_phase = PH_ITEMS;
					end else begin
						// no items at all: lone end marker
						nx_phase         = PH_DONE;
						emit             = 1'b1;
						r.item_kind      = ac019_pkg::KIND_END;
						r.last_of_record = 1'b1;
					end
				end
			end
			PH_ITEMS: begin
				r.item_kind = cur_cursor;
				if (cur_cursor == ac019_pkg::KIND_SENSOR) begin
					if (cur_bcnt == 4'd0) begin
						// entry count
						nx_reps = b;
						if (b == 8'd0) begin
							done = 1'b1;
						end else begin
							nx_bcnt = 4'd1;
						end
					end else if (cur_bcnt == 4'd1) begin
						nx_gather = {56'd0, b};
						nx_bcnt   = 4'd2;
					end else begin
						emit           = 1'b1;
						r.value_a      = {24'd0, cur_gather[7:0]};
						r.sensor_flags = b[6:2];
						nx_reps        = cur_reps - 8'd1;
						nx_bcnt        = 4'd1;
						if (cur_reps == 8'd1) begin
							done = 1'b1;
						end
					end
				end else if (cur_cursor == ac019_pkg::KIND_TRANSPONDER) begin
					emit       = 1'b1;
					r.value_a  = {29'd0, cur_oct};
					r.code_one = b[7:6];
					r.code_two = b[3:2];
					if (cur_oct != 3'd7) begin
						nx_oct = cur_oct + 3'd1;
					end
					if (!b[0]) begin
						done = 1'b1;
					end
				end else begin
					nx_gather = g_new;
					nx_bcnt   = bcnt_inc;
					if (bcnt_inc >= ac019_pkg::fixed_len(cur_cursor)) begin
						emit = 1'b1;
						done = 1'b1;
						unique case (cur_cursor)
							ac019_pkg::KIND_SOURCE: begin
								r.value_a = {24'd0, g_new[15:8]};
								r.value_b = {24'd0, g_new[7:0]};
							end
							ac019_pkg::KIND_MSG_TYPE: begin
								r.value_a  = {24'd0, g_new[7:0]};
								r.code_one = {1'b0, (g_new[7:0] >= 8'd1) &&
									(g_new[7:0] <= 8'd3)};
							end
							ac019_pkg::KIND_TIME: begin
								r.value_a = {5'd0, time_prod[30:4]};
							end
							ac019_pkg::KIND_SYS_STATUS: begin
								r.code_one   = g_new[7:6];
								r.code_two   = {1'b0, g_new[5]};
								r.code_three = {1'b0, g_new[4]};
								r.code_four  = {1'b0, g_new[3]};
							end
							ac019_pkg::KIND_TP_STATUS: begin
								r.code_one   = g_new[7:6];
								r.code_two   = g_new[5:4];
								r.code_three = g_new[3:2];
								r.code_four  = g_new[1:0];
							end
							ac019_pkg::KIND_POSITION: begin
								r.value_a = g_new[63:32];
								r.value_b = g_new[31:0];
							end
							ac019_pkg::KIND_HEIGHT: begin
								r.value_a = {{16{g_new[15]}}, g_new[15:0]};
							end
							default: begin
								r.value_a = {{24{g_new[7]}}, g_new[7:0]};
							end
						endcase
					end
				end

				// item finished: step to the next present item
				if (done) begin
					nx_cursor = after_item;
					nx_bcnt   = '0;
					nx_gather = '0;
					nx_reps   = '0;
					nx_oct    = '0;
					if (after_item >= 4'(NI)) begin
						nx_phase = PH_DONE;
						if (!emit) begin
							// empty sensor item closed the record
							r           = '0;
							r.item_kind = ac019_pkg::KIND_END;
							emit        = 1'b1;
						end
						r.last_of_record = 1'b1;
					end
				end
			end
			default: begin
				// idle or done: bytes without record_start are dropped
			end
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			data_s1 <= byte_data;
		end
	end

	// parser state, updated as each byte is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			pres_q   <= '0;
			cursor_q <= '0;
			bcnt_q   <= '0;
			gather_q <= '0;
			reps_q   <= '0;
			oct_q    <= '0;
		end else if (adv) begin
			phase_q  <= nx_phase;
			pres_q   <= nx_pres;
			cursor_q <= nx_cursor;
			bcnt_q   <= nx_bcnt;
			gather_q <= nx_gather;
			reps_q   <= nx_reps;
			oct_q    <= nx_oct;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= emit;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			res_q <= r;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/ac019_checker.sv -----
// port-level assertions for the category 19 record parser, with bind
`default_nettype none

module ac019_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            byte_valid,
	input wire logic            byte_ready,
	input wire ac019_pkg::in_t  byte_data,
	input wire logic            result_valid,
	input wire logic            result_ready,
	input wire ac019_pkg::out_t result_data
);

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_data))
		else $error("result changed while stalled");

	// an end marker always closes the record
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_data.item_kind == ac019_pkg::KIND_END)
		|-> result_data.last_of_record && (result_data.value_a == 0))
		else $error("end marker malformed");

	// value_b only carries sic or longitude
	a_value_b_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_data.item_kind != ac019_pkg::KIND_SOURCE) &&
		(result_data.item_kind != ac019_pkg::KIND_POSITION)
		|-> (result_data.value_b == 0))
		else $error("value_b set on wrong item");

	// sensor flags only on sensor entries
	a_flags_sensor: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_data.item_kind != ac019_pkg::KIND_SENSOR)
		|-> (result_data.sensor_flags == 5'd0))
		else $error("sensor flags on wrong item");

	// a result needs a byte: none appears after the input side idles with no result pending
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid && !(byte_valid && byte_ready) ##1
		!(byte_valid && byte_ready) |=> !$rose(result_valid) || $past(result_valid, 2)
		|| $past(byte_valid && byte_ready, 2))
		else $error("result without input");

endmodule

bind asterix_cat019_record_parser ac019_checker u_ac019_checker (.*);

`default_nettype wire
